// ----- design/rsd_pkg.sv -----
// ----------------------------------------------------------------------------
// rsd_pkg: shared types and constants for the rectangle symmetric difference
// Coordinate widths, the queue word that passes front to back, and the
// span test used by both halves.
// ----------------------------------------------------------------------------
package rsd_pkg;

   localparam int COORD_BITS = 16;
   localparam int SIZE_BITS  = COORD_BITS - 1;   // rectangle width / height
   localparam int EDGE_BITS  = COORD_BITS + 2;   // edge after adding a size
   localparam int POUT_BITS  = COORD_BITS + 1;   // piece_x / piece_y
   localparam int PSIZE_BITS = COORD_BITS;       // piece_w / piece_h
   localparam int TILES      = 9;
   localparam int QDEPTH     = 2;
   localparam int QPTR_BITS  = $clog2(QDEPTH);

   typedef logic signed [EDGE_BITS-1:0] edge_type;

   // One classified input pair.
   typedef struct packed {
      logic                        overlap;
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
      logic [SIZE_BITS-1:0]         aw;
      logic [SIZE_BITS-1:0]         ah;
      logic signed [COORD_BITS-1:0] bx;
      logic signed [COORD_BITS-1:0] by;
      logic [SIZE_BITS-1:0]         bw;
      logic [SIZE_BITS-1:0]         bh;
      edge_type                     xa_end;
      edge_type                     ya_end;
      edge_type                     xb_end;
      edge_type                     yb_end;
      edge_type [3:0]               gx;
      edge_type [3:0]               gy;
   } entry_type;

   function automatic edge_type coord_ext(input logic signed [COORD_BITS-1:0] v);
      return edge_type'(v);
   endfunction

   // Span [lo, hi) shares a point with [q, q_end).
   function automatic logic span_hit(input edge_type lo, input edge_type hi,
                                     input edge_type q, input edge_type q_end);
      return !((q_end <= lo) || (q >= hi));
   endfunction

endpackage

// ----- design/rsd_front.sv -----
// ----------------------------------------------------------------------------
// rsd_front: input stage and classifier
// Registers the pair with its far edges, then checks overlap and sorts the
// edges into the 3x3 grid bounds for the queue.
// ----------------------------------------------------------------------------
module rsd_front import rsd_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_ax,
   input  logic signed [COORD_BITS-1:0] req_ay,
   input  logic [SIZE_BITS-1:0]         req_aw,
   input  logic [SIZE_BITS-1:0]         req_ah,
   input  logic signed [COORD_BITS-1:0] req_bx,
   input  logic signed [COORD_BITS-1:0] req_by,
   input  logic [SIZE_BITS-1:0]         req_bw,
   input  logic [SIZE_BITS-1:0]         req_bh,
   output logic                         push_valid,
   input  logic                         push_full,
   output entry_type                    push_word
);

   logic      s1_valid_ff, s1_valid_in;
   entry_type s1_ff, s1_in;
   logic      advance;
   edge_type  axe, aye, bxe, bye;
   logic      x_hit, y_hit;

   // Hold the stage while the queue is full.
   assign advance   = !(s1_valid_ff && push_full);
   assign req_stall = !advance;

   always_comb begin
      s1_in        = s1_ff;
      s1_in.ax     = req_ax;
      s1_in.ay     = req_ay;
      s1_in.aw     = req_aw;
      s1_in.ah     = req_ah;
      s1_in.bx     = req_bx;
      s1_in.by     = req_by;
      s1_in.bw     = req_bw;
      s1_in.bh     = req_bh;
      s1_in.xa_end = coord_ext(req_ax) + edge_type'({3'b000, req_aw});
      s1_in.ya_end = coord_ext(req_ay) + edge_type'({3'b000, req_ah});
      s1_in.xb_end = coord_ext(req_bx) + edge_type'({3'b000, req_bw});
      s1_in.yb_end = coord_ext(req_by) + edge_type'({3'b000, req_bh});
      s1_valid_in  = advance ? req_valid : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         s1_ff <= s1_in;
      end
   end

   // Classify and sort.
   always_comb begin
      axe = coord_ext(s1_ff.ax);
      aye = coord_ext(s1_ff.ay);
      bxe = coord_ext(s1_ff.bx);
      bye = coord_ext(s1_ff.by);
      x_hit = span_hit(axe, s1_ff.xa_end, bxe, s1_ff.xb_end);
      y_hit = span_hit(aye, s1_ff.ya_end, bye, s1_ff.yb_end);

      push_word         = s1_ff;
      push_word.overlap = x_hit && y_hit;
      push_word.gx[0]   = (axe < bxe) ? axe : bxe;
      push_word.gx[1]   = (axe < bxe) ? bxe : axe;
      push_word.gx[2]   = (s1_ff.xa_end < s1_ff.xb_end) ? s1_ff.xa_end : s1_ff.xb_end;
      push_word.gx[3]   = (s1_ff.xa_end < s1_ff.xb_end) ? s1_ff.xb_end : s1_ff.xa_end;
      push_word.gy[0]   = (aye < bye) ? aye : bye;
      push_word.gy[1]   = (aye < bye) ? bye : aye;
      push_word.gy[2]   = (s1_ff.ya_end < s1_ff.yb_end) ? s1_ff.ya_end : s1_ff.yb_end;
      push_word.gy[3]   = (s1_ff.ya_end < s1_ff.yb_end) ? s1_ff.yb_end : s1_ff.ya_end;
   end

   assign push_valid = s1_valid_ff;

endmodule

// ----- design/rsd_queue.sv -----
// ----------------------------------------------------------------------------
// rsd_queue: short queue between front and back
// Two-entry first-in first-out buffer of classified pairs.
// ----------------------------------------------------------------------------
module rsd_queue import rsd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_full,
   input  entry_type push_word,
   output logic      pop_valid,
   input  logic      pop_take,
   output entry_type pop_word
);

   entry_type              slot_ff [QDEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_full = (count_ff == (QPTR_BITS+1)'(QDEPTH));
   assign pop_valid = (count_ff != '0);
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop_take && pop_valid;
   assign pop_word  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ----- design/rsd_back.sv -----
// ----------------------------------------------------------------------------
// rsd_back: tile scanner and result register
// Builds the qualifying-tile mask of a popped pair; unless stalled, it emits
// one piece a cycle to the output register, row by row and column by column.
// ----------------------------------------------------------------------------
module rsd_back import rsd_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop_valid,
   output logic                         pop_take,
   input  entry_type                    pop_word,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [POUT_BITS-1:0]  rsp_piece_x,
   output logic signed [POUT_BITS-1:0]  rsp_piece_y,
   output logic [PSIZE_BITS-1:0]        rsp_piece_w,
   output logic [PSIZE_BITS-1:0]        rsp_piece_h,
   output logic                         rsp_empty_res,
   output logic                         rsp_last
);

   entry_type                   work_ff, work_in;
   logic                        work_valid_ff, work_valid_in;
   logic [TILES-1:0]            rem_ff, rem_in;
   logic                        phase_ff, phase_in;
   logic [TILES-1:0]            head_mask;
   logic [2:0]                  xa_hit, xb_hit, ya_hit, yb_hit;

   logic                        out_free, step, done;
   logic [1:0]                  sel_r, sel_c;
   logic [TILES-1:0]            sel_bit;
   logic                        found;
   logic signed [POUT_BITS-1:0] item_x, item_y;
   logic [PSIZE_BITS-1:0]       item_w, item_h;
   logic                        item_empty, item_last;
   edge_type                    tile_w, tile_h;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [POUT_BITS-1:0] px_ff, py_ff;
   logic [PSIZE_BITS-1:0]       pw_ff, ph_ff;
   logic                        pe_ff, pl_ff;

   // Tile mask of the queue head: per-axis span tests, then combine.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         xa_hit[c] = span_hit(pop_word.gx[c], pop_word.gx[c+1],
                              coord_ext(pop_word.ax), pop_word.xa_end);
         xb_hit[c] = span_hit(pop_word.gx[c], pop_word.gx[c+1],
                              coord_ext(pop_word.bx), pop_word.xb_end);
         ya_hit[c] = span_hit(pop_word.gy[c], pop_word.gy[c+1],
                              coord_ext(pop_word.ay), pop_word.ya_end);
         yb_hit[c] = span_hit(pop_word.gy[c], pop_word.gy[c+1],
                              coord_ext(pop_word.by), pop_word.yb_end);
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            head_mask[r*3+c] = (xa_hit[c] && ya_hit[r]) ^ (xb_hit[c] && yb_hit[r]);
         end
      end
   end

   // Pick the lowest remaining tile.
   always_comb begin
      sel_r   = '0;
      sel_c   = '0;
      sel_bit = '0;
      found   = 1'b0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (!found && rem_ff[r*3+c]) begin
               found   = 1'b1;
               sel_r   = 2'(r);
               sel_c   = 2'(c);
               sel_bit = TILES'(1) << (r*3+c);
            end
         end
      end
   end

   // Build the current result word.
   always_comb begin
      tile_w     = work_ff.gx[sel_c + 2'd1] - work_ff.gx[sel_c];
      tile_h     = work_ff.gy[sel_r + 2'd1] - work_ff.gy[sel_r];
      item_x     = '0;
      item_y     = '0;
      item_w     = '0;
      item_h     = '0;
      item_empty = 1'b0;
      item_last  = 1'b0;
      if (!work_ff.overlap) begin
         if (!phase_ff) begin
            item_x = POUT_BITS'(work_ff.ax);
            item_y = POUT_BITS'(work_ff.ay);
            item_w = {1'b0, work_ff.aw};
            item_h = {1'b0, work_ff.ah};
         end else begin
            item_x    = POUT_BITS'(work_ff.bx);
            item_y    = POUT_BITS'(work_ff.by);
            item_w    = {1'b0, work_ff.bw};
            item_h    = {1'b0, work_ff.bh};
            item_last = 1'b1;
         end
      end else if (!found) begin
         item_empty = 1'b1;
         item_last  = 1'b1;
      end else begin
         item_x    = work_ff.gx[sel_c][POUT_BITS-1:0];
         item_y    = work_ff.gy[sel_r][POUT_BITS-1:0];
         item_w    = tile_w[PSIZE_BITS-1:0];
         item_h    = tile_h[PSIZE_BITS-1:0];
         item_last = ((rem_ff & ~sel_bit) == '0);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign step     = work_valid_ff && out_free;
   assign done     = step && item_last;
   assign pop_take = pop_valid && (!work_valid_ff || done);

   always_comb begin
      work_in       = work_ff;
      work_valid_in = work_valid_ff;
      rem_in        = rem_ff;
      phase_in      = phase_ff;
      if (pop_take) begin
         work_in       = pop_word;
         work_valid_in = 1'b1;
         rem_in        = head_mask;
         phase_in      = 1'b0;
      end else if (done) begin
         work_valid_in = 1'b0;
      end else if (step) begin
         rem_in   = rem_ff & ~sel_bit;
         phase_in = 1'b1;
      end
      rsp_valid_in = step ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      phase_ff <= phase_in;
      if (step) begin
         px_ff <= item_x;
         py_ff <= item_y;
         pw_ff <= item_w;
         ph_ff <= item_h;
         pe_ff <= item_empty;
         pl_ff <= item_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_piece_x   = px_ff;
   assign rsp_piece_y   = py_ff;
   assign rsp_piece_w   = pw_ff;
   assign rsp_piece_h   = ph_ff;
   assign rsp_empty_res = pe_ff;
   assign rsp_last      = pl_ff;

endmodule

// ----- design/rect_symmetric_difference_top.sv -----
// ----------------------------------------------------------------------------
// rect_symmetric_difference_top: split two rectangles into difference tiles
// Top level: front classifier, two-word queue, back tile scanner.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one word carries rectangles A and B as left
//   edge, top edge, width, height. It is taken on a clock edge with
//   req_valid high and req_stall low.
//   Response channel (rsp_*): one word per piece. Disjoint pairs give A then
//   B. Overlapping pairs give every tile of the 3x3 edge grid covered by
//   exactly one rectangle, rows outer, columns inner; if none qualifies a
//   single word with rsp_empty_res set and zero geometry is given.
//   rsp_last marks the final word of each pair.
// Path: after a pair is taken, its first word passes through the queue,
//   the scanner register and the output register in turn.
// Throughput: the back scanner emits one word per cycle while rsp_stall is
//   low, so a pair gives max(pieces, 1) words: 2 for disjoint pairs, 1 to 8
//   otherwise. The front takes a word every cycle while the queue has room.
// Reset: synchronous, active high; empties input stage, queue, scanner and
//   output register. No clearing pass.
// Stall: rsp_stall holds the output word; the scanner and then the queue
//   fill up, after which req_stall rises.
// ----------------------------------------------------------------------------
module rect_symmetric_difference_top import rsd_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_ax,
   input  logic signed [COORD_BITS-1:0] req_ay,
   input  logic [SIZE_BITS-1:0]         req_aw,
   input  logic [SIZE_BITS-1:0]         req_ah,
   input  logic signed [COORD_BITS-1:0] req_bx,
   input  logic signed [COORD_BITS-1:0] req_by,
   input  logic [SIZE_BITS-1:0]         req_bw,
   input  logic [SIZE_BITS-1:0]         req_bh,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [POUT_BITS-1:0]  rsp_piece_x,
   output logic signed [POUT_BITS-1:0]  rsp_piece_y,
   output logic [PSIZE_BITS-1:0]        rsp_piece_w,
   output logic [PSIZE_BITS-1:0]        rsp_piece_h,
   output logic                         rsp_empty_res,
   output logic                         rsp_last
);

   // Front to queue
   logic      push_valid, push_full;
   entry_type push_word;
   // Queue to back
   logic      pop_valid, pop_take;
   entry_type pop_word;

   // Accept and classify the pair.
   rsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_ax     (req_ax),
      .req_ay     (req_ay),
      .req_aw     (req_aw),
      .req_ah     (req_ah),
      .req_bx     (req_bx),
      .req_by     (req_by),
      .req_bw     (req_bw),
      .req_bh     (req_bh),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_word  (push_word)
   );

   // Decouple the classifier from the scanner.
   rsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_word  (push_word),
      .pop_valid  (pop_valid),
      .pop_take   (pop_take),
      .pop_word   (pop_word)
   );

   // Scan tiles and drive the response channel.
   rsd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_take      (pop_take),
      .pop_word      (pop_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_piece_x   (rsp_piece_x),
      .rsp_piece_y   (rsp_piece_y),
      .rsp_piece_w   (rsp_piece_w),
      .rsp_piece_h   (rsp_piece_h),
      .rsp_empty_res (rsp_empty_res),
      .rsp_last      (rsp_last)
   );

   // An empty-result word always closes its pair.
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_res) |-> rsp_last)
      else $error("empty result without last");

   // An empty-result word carries zero geometry.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_res) |->
         (rsp_piece_x == '0 && rsp_piece_y == '0 &&
          rsp_piece_w == '0 && rsp_piece_h == '0))
      else $error("empty result with nonzero geometry");

   // Input stalls only while the front holds a word the queue cannot take.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (push_valid && push_full))
      else $error("request stalled without a full queue");

endmodule
